// ----- src/dpsf_pkg.sv -----
package dpsf_pkg;

   localparam int MAX_PREAMBLE_DEF   = 30;
   localparam int CUTOUT_SYMBOLS_DEF = 4;

   localparam int TICK_W  = 15;
   localparam int CSR_W   = 15;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ONE_BIT_TICKS    = 3'd0,
      CSR_ZERO_BIT_TICKS   = 3'd1,
      CSR_END_BIT_TICKS    = 3'd2,
      CSR_CUTOUT_TICKS     = 3'd3,
      CSR_PREAMBLE_COUNT   = 3'd4,
      CSR_FIRST_HALF_LEVEL = 3'd5,
      CSR_LEAD_ZERO_ENABLE = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_CUTOUT   = 3'd0,
      KIND_LEADZ    = 3'd1,
      KIND_PREAMBLE = 3'd2,
      KIND_START    = 3'd3,
      KIND_DATA     = 3'd4,
      KIND_END      = 3'd5
   } symbol_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CUTOUT,
      ST_LEADZ,
      ST_PREAMBLE,
      ST_START,
      ST_DATA,
      ST_END
   } state_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       final_byte;
   } req_word_type;

   typedef struct packed {
      logic              lead_level;
      logic [TICK_W-1:0] lead_ticks;
      logic              trail_level;
      logic [TICK_W-1:0] trail_ticks;
      logic [2:0]        symbol_kind;
      logic              run_last;
   } rsp_word_type;

endpackage

// ----- src/dcc_packet_symbol_framer.sv -----
// channel  | valid      | stall      | word
// ---------+------------+------------+----------------------------------------
// request  | req_valid  | req_stall  | req_word  (packet_byte, final_byte)
// response | rsp_valid  | rsp_stall  | rsp_word  (one two-phase symbol)
// config   | csr_write  | -          | csr_index, csr_data
//
// one symbol per cycle from a sequencer unless rsp_stall holds it; a byte shifts out one bit per data symbol
// inside a packet a byte is a start symbol and a data symbol per bit, then an end symbol
// when it ends one; when it opens one, CUTOUT_SYMBOLS cutout symbols if due, a lead zero
// if enabled and one to MAX_PREAMBLE preamble symbols come first
// req_stall stays high from acceptance until the last symbol is in the output register
// rsp_stall holds the output register and the sequencer; reset is synchronous
module dcc_packet_symbol_framer #(
   parameter int MAX_PREAMBLE   = dpsf_pkg::MAX_PREAMBLE_DEF,
   parameter int CUTOUT_SYMBOLS = dpsf_pkg::CUTOUT_SYMBOLS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dpsf_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dpsf_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_write,
   input  logic [dpsf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dpsf_pkg::CSR_W-1:0]          csr_data
);
   import dpsf_pkg::*;

   localparam int CNT_MAX_A = (MAX_PREAMBLE > CUTOUT_SYMBOLS) ? MAX_PREAMBLE : CUTOUT_SYMBOLS;
   localparam int CNT_MAX   = (CNT_MAX_A > 8) ? CNT_MAX_A : 8;
   localparam int CNT_W     = $clog2(CNT_MAX + 1);

   logic [TICK_W-1:0] one_ticks_ff, zero_ticks_ff, end_ticks_ff, cutout_ticks_ff;
   logic [4:0]        preamble_ff;
   logic              level_ff, lead_zero_ff;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [7:0]        shift_ff, shift_in;
   logic              final_ff, final_in;
   logic              inside_packet_ff, inside_packet_in;
   logic              cutout_due_ff, cutout_due_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic              req_take, out_free, emit;
   logic [CNT_W-1:0]  pre_load;
   state_type         open_state;
   symbol_kind_type   kind;
   logic [TICK_W-1:0] t0, t1;
   logic              last_sym;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = (state_ff != ST_IDLE) && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         one_ticks_ff    <= TICK_W'(58);
         zero_ticks_ff   <= TICK_W'(100);
         end_ticks_ff    <= '0;
         cutout_ticks_ff <= '0;
         preamble_ff     <= 5'd17;
         level_ff        <= 1'b0;
         lead_zero_ff    <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ONE_BIT_TICKS:    one_ticks_ff    <= csr_data;
            CSR_ZERO_BIT_TICKS:   zero_ticks_ff   <= csr_data;
            CSR_END_BIT_TICKS:    end_ticks_ff    <= csr_data;
            CSR_CUTOUT_TICKS:     cutout_ticks_ff <= csr_data;
            CSR_PREAMBLE_COUNT:   preamble_ff     <= csr_data[4:0];
            CSR_FIRST_HALF_LEVEL: level_ff        <= csr_data[0];
            CSR_LEAD_ZERO_ENABLE: lead_zero_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // saturated preamble length minus one; a length of zero counts as one
   always_comb begin
      if (preamble_ff == 5'd0) begin
         pre_load = '0;
      end else if (32'(preamble_ff) > 32'(MAX_PREAMBLE)) begin
         pre_load = CNT_W'(MAX_PREAMBLE - 1);
      end else begin
         pre_load = CNT_W'(preamble_ff - 5'd1);
      end
   end

   always_comb begin
      if (inside_packet_ff) begin
         open_state = ST_START;
      end else if (cutout_due_ff && (cutout_ticks_ff != '0)) begin
         open_state = ST_CUTOUT;
      end else if (lead_zero_ff) begin
         open_state = ST_LEADZ;
      end else begin
         open_state = ST_PREAMBLE;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = open_state;
         end
         ST_CUTOUT: begin
            if (emit && cnt_ff == '0) state_in = lead_zero_ff ? ST_LEADZ : ST_PREAMBLE;
         end
         ST_LEADZ: begin
            if (emit) state_in = ST_PREAMBLE;
         end
         ST_PREAMBLE: begin
            if (emit && cnt_ff == '0) state_in = ST_START;
         end
         ST_START: begin
            if (emit) state_in = ST_DATA;
         end
         ST_DATA: begin
            if (emit && cnt_ff == '0) state_in = final_ff ? ST_END : ST_IDLE;
         end
         ST_END: begin
            if (emit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cnt_in           = cnt_ff;
      shift_in         = shift_ff;
      final_in         = final_ff;
      inside_packet_in = inside_packet_ff;
      cutout_due_in    = cutout_due_ff;
      kind             = KIND_CUTOUT;
      t0               = cutout_ticks_ff;
      t1               = cutout_ticks_ff;
      last_sym         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               shift_in         = req_word.packet_byte;
               final_in         = req_word.final_byte;
               inside_packet_in = !req_word.final_byte;
               cutout_due_in    = cutout_due_ff | req_word.final_byte;
               if (open_state == ST_CUTOUT) begin
                  cnt_in = CNT_W'(CUTOUT_SYMBOLS - 1);
               end else begin
                  cnt_in = pre_load;
               end
            end
         end
         ST_CUTOUT: begin
            if (emit) cnt_in = (cnt_ff == '0) ? pre_load : cnt_ff - CNT_W'(1);
         end
         ST_LEADZ: begin
            kind = KIND_LEADZ;
            t0   = zero_ticks_ff;
            t1   = zero_ticks_ff;
            if (emit) cnt_in = pre_load;
         end
         ST_PREAMBLE: begin
            kind = KIND_PREAMBLE;
            t0   = one_ticks_ff;
            t1   = one_ticks_ff;
            if (emit && cnt_ff != '0) cnt_in = cnt_ff - CNT_W'(1);
         end
         ST_START: begin
            kind = KIND_START;
            t0   = zero_ticks_ff;
            t1   = zero_ticks_ff;
            if (emit) cnt_in = CNT_W'(7);
         end
         ST_DATA: begin
            kind     = KIND_DATA;
            t0       = shift_ff[7] ? one_ticks_ff : zero_ticks_ff;
            t1       = t0;
            last_sym = (cnt_ff == '0) && !final_ff;
            if (emit) begin
               shift_in = {shift_ff[6:0], 1'b0};
               if (cnt_ff != '0) cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_END: begin
            kind     = KIND_END;
            t0       = one_ticks_ff;
            t1       = (end_ticks_ff != '0) ? end_ticks_ff : one_ticks_ff;
            last_sym = 1'b1;
         end
         default: ;
      endcase

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (emit) begin
         rsp_valid_in            = 1'b1;
         rsp_word_in.lead_level  = level_ff;
         rsp_word_in.lead_ticks  = t0;
         rsp_word_in.trail_level = !level_ff;
         rsp_word_in.trail_ticks = t1;
         rsp_word_in.symbol_kind = kind;
         rsp_word_in.run_last    = last_sym;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         inside_packet_ff <= 1'b0;
         cutout_due_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         inside_packet_ff <= inside_packet_in;
         cutout_due_ff    <= cutout_due_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      shift_ff    <= shift_in;
      final_ff    <= final_in;
      rsp_word_ff <= rsp_word_in;
   end

   a_open_has_preamble: assert property (@(posedge clock) disable iff (reset)
      req_take && !inside_packet_ff |=> state_ff != ST_START && state_ff != ST_DATA)
      else $error("packet opened without preamble");

   a_cutout_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.symbol_kind == KIND_CUTOUT |-> cutout_due_ff)
      else $error("cutout before any packet ended");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.symbol_kind == KIND_END |-> rsp_word_ff.run_last)
      else $error("end bit not marked last");

endmodule

// ----- test/dcc_symbol_checker.sv -----
module dcc_symbol_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  dpsf_pkg::req_word_type         req_word,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  dpsf_pkg::rsp_word_type         rsp_word,
   input  logic                           csr_write,
   input  logic [dpsf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dpsf_pkg::CSR_W-1:0]     csr_data,
   output int                             failures,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import dpsf_pkg::*;

   logic [TICK_W-1:0] one_ticks;
   logic [TICK_W-1:0] zero_ticks;
   logic [TICK_W-1:0] end_ticks;
   logic [TICK_W-1:0] cut_ticks;
   logic [4:0]        preamble_len;
   logic              lead_level_cfg;
   logic              lead_zero_on;

   logic packet_open;
   logic cutout_armed;

   rsp_word_type symbol_queue[$];

   initial begin
      failures = 0;
      pending = 0;
   end

   function void push_symbol(input logic [TICK_W-1:0] t0, input logic [TICK_W-1:0] t1,
                             input symbol_kind_type kind, input logic last);
      rsp_word_type w;
      w.lead_level  = lead_level_cfg;
      w.lead_ticks  = t0;
      w.trail_level = ~lead_level_cfg;
      w.trail_ticks = t1;
      w.symbol_kind = kind;
      w.run_last    = last;
      symbol_queue.push_back(w);
   endfunction

   function void frame_byte(input req_word_type w);
      int run;
      logic [TICK_W-1:0] t;
      if (!packet_open) begin
         if (cutout_armed && cut_ticks != '0)
            for (int i = 0; i < CUTOUT_SYMBOLS_DEF; i++)
               push_symbol(cut_ticks, cut_ticks, KIND_CUTOUT, 1'b0);
         if (lead_zero_on)
            push_symbol(zero_ticks, zero_ticks, KIND_LEADZ, 1'b0);
         run = preamble_len;
         if (run < 1)
            run = 1;
         if (run > MAX_PREAMBLE_DEF)
            run = MAX_PREAMBLE_DEF;
         for (int i = 0; i < run; i++)
            push_symbol(one_ticks, one_ticks, KIND_PREAMBLE, 1'b0);
      end
      push_symbol(zero_ticks, zero_ticks, KIND_START, 1'b0);
      for (int i = 7; i >= 0; i--) begin
         t = w.packet_byte[i] ? one_ticks : zero_ticks;
         push_symbol(t, t, KIND_DATA, i == 0 && !w.final_byte);
      end
      if (w.final_byte) begin
         push_symbol(one_ticks, (end_ticks != '0) ? end_ticks : one_ticks, KIND_END, 1'b1);
         packet_open = 1'b0;
         cutout_armed = 1'b1;
      end else begin
         packet_open = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type exp;
      logic bad;
      if (reset) begin
         one_ticks      = 15'd58;
         zero_ticks     = 15'd100;
         end_ticks      = '0;
         cut_ticks      = '0;
         preamble_len   = 5'd17;
         lead_level_cfg = 1'b0;
         lead_zero_on   = 1'b0;
         packet_open    = 1'b0;
         cutout_armed   = 1'b0;
         symbol_queue.delete();
      end else begin
         if (req_valid && !req_stall)
            frame_byte(req_word);
         if (rsp_valid && !rsp_stall) begin
            if (symbol_queue.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("mismatch: unexpected word kind %0d lead %0b/%0d trail %0b/%0d last %0b",
                           rsp_word.symbol_kind, rsp_word.lead_level, rsp_word.lead_ticks,
                           rsp_word.trail_level, rsp_word.trail_ticks, rsp_word.run_last);
            end else begin
               exp = symbol_queue.pop_front();
               bad = (rsp_word.lead_level !== exp.lead_level)
                  || (rsp_word.lead_ticks !== exp.lead_ticks)
                  || (rsp_word.trail_level !== exp.trail_level)
                  || (rsp_word.trail_ticks !== exp.trail_ticks)
                  || (rsp_word.symbol_kind !== exp.symbol_kind)
                  || (rsp_word.run_last !== exp.run_last);
               if (bad) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("mismatch: expected kind %0d lead %0b/%0d trail %0b/%0d last %0b",
                              exp.symbol_kind, exp.lead_level, exp.lead_ticks,
                              exp.trail_level, exp.trail_ticks, exp.run_last);
                     $display("          actual   kind %0d lead %0b/%0d trail %0b/%0d last %0b",
                              rsp_word.symbol_kind, rsp_word.lead_level, rsp_word.lead_ticks,
                              rsp_word.trail_level, rsp_word.trail_ticks, rsp_word.run_last);
                  end
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_ONE_BIT_TICKS:    one_ticks = csr_data[TICK_W-1:0];
               CSR_ZERO_BIT_TICKS:   zero_ticks = csr_data[TICK_W-1:0];
               CSR_END_BIT_TICKS:    end_ticks = csr_data[TICK_W-1:0];
               CSR_CUTOUT_TICKS:     cut_ticks = csr_data[TICK_W-1:0];
               CSR_PREAMBLE_COUNT:   preamble_len = csr_data[4:0];
               CSR_FIRST_HALF_LEVEL: lead_level_cfg = csr_data[0];
               CSR_LEAD_ZERO_ENABLE: lead_zero_on = csr_data[0];
               default: ;
            endcase
         end
      end
      pending <= symbol_queue.size();
   end

endmodule

// ----- test/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dpsf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam int RANDOM_ITEMS = 380;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_word_type         req_word = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_word_type         rsp_word;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data = '0;

   int   mismatch_total;
   int   symbols_pending;
   logic hold_go = 1'b0;
   int   burst_left = 0;
   bit   sender_steady = 1'b0;

   logic [CSR_W-1:0] reg_value [0:6];

   dcc_packet_symbol_framer uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   dcc_symbol_checker symbol_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .failures(mismatch_total),
      .pending(symbols_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("tb: failure");
      $finish;
   end

   // receiver stall patterns, with one long hold-off on request
   initial begin : receiver
      int  mode;
      int  span;
      int  hold_left;
      int  step;
      bit  hold_done;
      hold_left = 0;
      step = 0;
      hold_done = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(40, 300);
         repeat (span) begin
            @(posedge clock);
            step++;
            if (hold_go && !hold_done) begin
               hold_done = 1'b1;
               hold_left = 500;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_stall <= 1'b1;
            end else begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 1) == 0);
                  2: rsp_stall <= ($urandom_range(0, 7) == 0);
                  default: rsp_stall <= (step % 5) < 3;
               endcase
            end
         end
      end
   end

   task automatic offer_byte(input logic [7:0] value, input logic last);
      int gap;
      req_word <= {value, last};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         if (!sender_steady) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 5);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_packet(input int len, input bit leave_open);
      for (int k = 0; k < len; k++)
         offer_byte(8'($urandom), k == len - 1 && !leave_open);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (symbols_pending != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_registers(input bit spare);
      for (int i = 0; i < $size(reg_value); i++) begin
         csr_write <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data <= reg_value[i];
         @(posedge clock);
      end
      if (spare) begin
         csr_index <= CSR_SPARE_INDEX;
         csr_data <= CSR_W'($urandom);
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   function automatic logic [CSR_W-1:0] pick_ticks();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 15'd1;
         3, 4, 5: return CSR_W'($urandom_range(1, 255));
         default: return CSR_W'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      int random_sent;
      int quota;
      int len;
      int phase;
      bit leave_open;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, first packet has no cutout
      offer_byte(8'h00, 1'b1);
      settle();

      reg_value[CSR_ONE_BIT_TICKS]    = 15'd58;
      reg_value[CSR_ZERO_BIT_TICKS]   = 15'd100;
      reg_value[CSR_END_BIT_TICKS]    = '0;
      reg_value[CSR_CUTOUT_TICKS]     = '1;
      reg_value[CSR_PREAMBLE_COUNT]   = 15'd17;
      reg_value[CSR_FIRST_HALF_LEVEL] = 15'd1;
      reg_value[CSR_LEAD_ZERO_ENABLE] = 15'd1;
      load_registers(1'b1);
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'hA5, 1'b1);
      settle();

      // zero durations, preamble of zero, masked upper bits
      reg_value[CSR_ONE_BIT_TICKS]    = '0;
      reg_value[CSR_ZERO_BIT_TICKS]   = '0;
      reg_value[CSR_END_BIT_TICKS]    = '1;
      reg_value[CSR_CUTOUT_TICKS]     = 15'd1;
      reg_value[CSR_PREAMBLE_COUNT]   = 15'h7FE0;
      reg_value[CSR_FIRST_HALF_LEVEL] = 15'h7FFE;
      reg_value[CSR_LEAD_ZERO_ENABLE] = 15'h7FFE;
      load_registers(1'b0);
      offer_byte(8'h5A, 1'b1);
      settle();

      // preamble saturation, then new settings inside an open packet
      reg_value[CSR_ONE_BIT_TICKS]    = '1;
      reg_value[CSR_ZERO_BIT_TICKS]   = 15'd1;
      reg_value[CSR_END_BIT_TICKS]    = 15'd1;
      reg_value[CSR_CUTOUT_TICKS]     = '0;
      reg_value[CSR_PREAMBLE_COUNT]   = '1;
      reg_value[CSR_FIRST_HALF_LEVEL] = 15'd1;
      reg_value[CSR_LEAD_ZERO_ENABLE] = 15'd1;
      load_registers(1'b0);
      offer_byte(8'h80, 1'b0);
      settle();
      reg_value[CSR_ONE_BIT_TICKS]    = 15'd3;
      reg_value[CSR_ZERO_BIT_TICKS]   = 15'd5;
      reg_value[CSR_END_BIT_TICKS]    = '0;
      load_registers(1'b1);
      offer_byte(8'h01, 1'b1);
      settle();

      reg_value[CSR_ONE_BIT_TICKS]    = 15'd1;
      reg_value[CSR_ZERO_BIT_TICKS]   = '1;
      reg_value[CSR_END_BIT_TICKS]    = 15'd2;
      reg_value[CSR_CUTOUT_TICKS]     = 15'd9;
      reg_value[CSR_PREAMBLE_COUNT]   = 15'd1;
      reg_value[CSR_FIRST_HALF_LEVEL] = '0;
      reg_value[CSR_LEAD_ZERO_ENABLE] = 15'd1;
      load_registers(1'b0);
      offer_byte(8'h3C, 1'b0);
      offer_byte(8'hC3, 1'b0);
      offer_byte(8'h0F, 1'b1);
      offer_byte(8'hFE, 1'b1);
      settle();

      // longest opening run
      reg_value[CSR_CUTOUT_TICKS]     = '1;
      reg_value[CSR_PREAMBLE_COUNT]   = 15'd30;
      reg_value[CSR_FIRST_HALF_LEVEL] = 15'd1;
      load_registers(1'b0);
      offer_byte(8'h7F, 1'b1);
      send_packet(3, 1'b0);
      settle();

      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         reg_value[CSR_ONE_BIT_TICKS]    = pick_ticks();
         reg_value[CSR_ZERO_BIT_TICKS]   = pick_ticks();
         reg_value[CSR_END_BIT_TICKS]    = ($urandom_range(0, 2) == 0) ? '0 : pick_ticks();
         reg_value[CSR_CUTOUT_TICKS]     = ($urandom_range(0, 2) == 0) ? '0 : pick_ticks();
         reg_value[CSR_PREAMBLE_COUNT]   = CSR_W'($urandom);
         reg_value[CSR_FIRST_HALF_LEVEL] = CSR_W'($urandom);
         reg_value[CSR_LEAD_ZERO_ENABLE] = CSR_W'($urandom);
         load_registers($urandom_range(0, 3) == 0);
         sender_steady = ($urandom_range(0, 3) == 0);
         if (phase == 1)
            hold_go <= 1'b1;
         quota = $urandom_range(25, 50);
         while (quota > 0) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            leave_open = (len >= quota) && ($urandom_range(0, 3) == 0);
            send_packet(len, leave_open);
            quota -= len;
            random_sent += len;
         end
         settle();
         phase++;
      end

      repeat (16) @(posedge clock);
      if (mismatch_total == 0 && symbols_pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- files.f -----
src/dpsf_pkg.sv
src/dcc_packet_symbol_framer.sv
test/dcc_symbol_checker.sv
test/testbench.sv
